FILE: rtl/arxcbc_pkg.sv
// ----------------------------------------------------------------------------
// arxcbc_pkg: shared types and constants of the ARX CBC block cipher
// Word and block types, round key store geometry, key schedule constants,
// register indexes and rotate helpers.
// ----------------------------------------------------------------------------
package arxcbc_pkg;

   localparam int WORD_W   = 32;
   localparam int BLOCK_W  = 128;
   localparam int HALF_W   = 64;
   localparam int NROUNDS  = 64;
   localparam int RK_AW    = $clog2(NROUNDS);
   localparam int CSR_DW   = 64;
   localparam int CSR_AW   = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [RK_AW-1:0] RK_FIRST = '0;
   localparam logic [RK_AW-1:0] RK_LAST  = RK_AW'(NROUNDS - 1);
   localparam logic [RK_AW-1:0] RK_MIX_LAST = RK_AW'(NROUNDS - 2);

   // four 32-bit words, word 0 in the top bits
   typedef logic [0:3][WORD_W-1:0] quad_type;

   localparam quad_type MIX_CONST = {32'hb5232c67, 32'habdd2f50, 32'hab790aaa, 32'he8395ac0};

   localparam logic [REG_IDX_W-1:0] REG_KEY_W0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_W1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY_W2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY_W3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_IV_HI  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_IV_LO  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd6;

   function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] a,
                                               input int unsigned n);
      return (a << n) | (a >> (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] a,
                                               input int unsigned n);
      return (a >> n) | (a << (WORD_W - n));
   endfunction

endpackage

FILE: rtl/arxcbc_if.sv
// ----------------------------------------------------------------------------
// arxcbc_if: valid/ready channels of the ARX CBC block cipher
// Request channel carries one input block, response channel one result block.
// ----------------------------------------------------------------------------
interface arxcbc_req_if;
   import arxcbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] block_hi;
   logic [HALF_W-1:0] block_lo;
   logic              chain_restart;

   modport source (output valid, block_hi, block_lo, chain_restart, input ready);
   modport sink   (input valid, block_hi, block_lo, chain_restart, output ready);
endinterface

interface arxcbc_rsp_if;
   import arxcbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] out_hi;
   logic [HALF_W-1:0] out_lo;

   modport source (output valid, out_hi, out_lo, input ready);
   modport sink   (input valid, out_hi, out_lo, output ready);
endinterface

FILE: rtl/arxcbc_ram.sv
// ----------------------------------------------------------------------------
// arxcbc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arxcbc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/arxcbc_round.sv
// ----------------------------------------------------------------------------
// arxcbc_round: shared round unit
// One forward or one inverse add/rotate/xor round on four words.
// ----------------------------------------------------------------------------
module arxcbc_round (
   input  arxcbc_pkg::quad_type state_in,
   input  arxcbc_pkg::quad_type round_key,
   input  logic                 inverse,
   output arxcbc_pkg::quad_type state_out
);
   import arxcbc_pkg::*;

   quad_type x;
   quad_type k;
   quad_type fwd;
   quad_type inv;

   assign x = state_in;
   assign k = round_key;

   always_comb begin
      fwd[1] = rol32(x[1] + x[2], 5) ^ x[0] ^ k[1];
      fwd[2] = rol32(x[2] + fwd[1], 9) ^ x[3] ^ k[2];
      fwd[0] = ror32(x[0] + fwd[2], 6) ^ x[3] ^ k[0];
      fwd[3] = ror32(x[3] + fwd[0], 11) ^ fwd[1] ^ k[3];

      inv[3] = rol32(x[3] ^ k[3] ^ x[1], 11) - x[0];
      inv[0] = rol32(x[0] ^ k[0] ^ inv[3], 6) - x[2];
      inv[2] = ror32(x[2] ^ k[2] ^ inv[3], 9) - x[1];
      inv[1] = ror32(x[1] ^ k[1] ^ inv[0], 5) - inv[2];
   end

   assign state_out = inverse ? inv : fwd;

endmodule

FILE: rtl/arx_block_cipher_cbc_unit.sv
// ----------------------------------------------------------------------------
// arx_block_cipher_cbc_unit: 128-bit ARX block cipher, 256-bit key, CBC mode
// Rounds: one round per cycle through the shared round unit, reading one round
//   key a cycle; a new block is taken only in idle, once the last result is stored.
// Key expansion: after reset or any register write the first block first runs
//   the key expansion, a KEY_S and a KEY_T step per mixed round key.
// Reset: synchronous, active high; registers, chain value and output valid
//   clear, and the round keys are marked stale.
// ----------------------------------------------------------------------------
module arx_block_cipher_cbc_unit (
   input  logic                            clock,
   input  logic                            reset,
   arxcbc_req_if.sink                      req_chan,
   arxcbc_rsp_if.source                    rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [arxcbc_pkg::CSR_AW-1:0]   paddr,
   input  logic [arxcbc_pkg::CSR_DW-1:0]   pwdata,
   output logic [arxcbc_pkg::CSR_DW-1:0]   prdata,
   output logic                            pready
);
   import arxcbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_KEY_LOAD, ST_KEY_S, ST_KEY_T, ST_KEY_LAST, ST_PREP, ST_ROUND, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [RK_AW-1:0]  cnt_ff;
   quad_type          s_ff, t_ff, w_ff, blk_ff, chain_ff;
   logic              restart_ff;
   logic              keys_stale_ff;
   logic              rsp_valid_ff;
   logic [BLOCK_W-1:0] out_ff;

   logic [HALF_W-1:0] key_w0_ff, key_w1_ff, key_w2_ff, key_w3_ff;
   logic [HALF_W-1:0] iv_hi_ff, iv_lo_ff;
   logic              mode_ff;

   // configuration port
   logic                 csr_we;
   logic                 csr_hit;
   logic [REG_IDX_W-1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_we  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_AW-1:CSR_AW-REG_IDX_W];

   always_comb begin
      csr_hit = 1'b0;
      prdata  = '0;
      unique case (csr_idx)
         REG_KEY_W0: begin csr_hit = 1'b1; prdata = key_w0_ff; end
         REG_KEY_W1: begin csr_hit = 1'b1; prdata = key_w1_ff; end
         REG_KEY_W2: begin csr_hit = 1'b1; prdata = key_w2_ff; end
         REG_KEY_W3: begin csr_hit = 1'b1; prdata = key_w3_ff; end
         REG_IV_HI:  begin csr_hit = 1'b1; prdata = iv_hi_ff; end
         REG_IV_LO:  begin csr_hit = 1'b1; prdata = iv_lo_ff; end
         REG_MODE:   begin csr_hit = 1'b1; prdata = CSR_DW'(mode_ff); end
         default:    begin csr_hit = 1'b0; prdata = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_w0_ff <= '0;
         key_w1_ff <= '0;
         key_w2_ff <= '0;
         key_w3_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
         mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_KEY_W0: key_w0_ff <= pwdata;
            REG_KEY_W1: key_w1_ff <= pwdata;
            REG_KEY_W2: key_w2_ff <= pwdata;
            REG_KEY_W3: key_w3_ff <= pwdata;
            REG_IV_HI:  iv_hi_ff  <= pwdata;
            REG_IV_LO:  iv_lo_ff  <= pwdata;
            REG_MODE:   mode_ff   <= pwdata[0];
            default:    ;
         endcase
      end
   end

   // key schedule mixing, on a view rotated so that word a sits at place 0
   logic [1:0] off;
   quad_type   sr, tr, sn, tn, s_mix_in, t_mix_in, k_first, k_last;

   assign off     = cnt_ff[1:0] - 2'd1;
   assign k_first = {key_w0_ff, key_w1_ff};
   assign k_last  = {key_w2_ff, key_w3_ff};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sr[k] = s_ff[2'(off + 2'(k))];
         tr[k] = t_ff[2'(off + 2'(k))];
      end
      sn[0] = sr[0] ^ (rol32(tr[0], 6)  + rol32(sr[3], 5));
      sn[1] = sr[1] ^ (rol32(tr[1], 10) + rol32(sr[2], 9));
      sn[2] = sr[2] ^ (rol32(tr[2], 7)  + rol32(sn[0], 6));
      sn[3] = sr[3] ^ (rol32(tr[3], 12) + rol32(sn[1], 11));
      tn[0] = tr[0] ^ (rol32(sr[0], 6)  + rol32(tr[3], 5));
      tn[1] = tr[1] ^ (rol32(sr[1], 10) + rol32(tn[0], 9));
      tn[2] = tr[2] ^ (rol32(sr[2], 7)  + rol32(tn[1], 6));
      tn[3] = tr[3] ^ (rol32(sr[3], 12) + rol32(tn[2], 11));
      s_mix_in = s_ff;
      t_mix_in = t_ff;
      for (int k = 0; k < 4; k++) begin
         s_mix_in[2'(off + 2'(k))] = sn[k];
         t_mix_in[2'(off + 2'(k))] = tn[k];
      end
   end

   // round key store
   logic               rk_we;
   logic [RK_AW-1:0]   rk_wr_addr;
   logic [BLOCK_W-1:0] rk_wr_data;
   logic [RK_AW-1:0]   rd_cnt;
   logic [RK_AW-1:0]   rk_rd_addr;
   logic [BLOCK_W-1:0] rk_rd_data;

   always_comb begin
      rk_we      = 1'b0;
      rk_wr_addr = cnt_ff;
      rk_wr_data = s_mix_in;
      unique case (state_ff)
         ST_KEY_LOAD: begin
            rk_we      = 1'b1;
            rk_wr_addr = RK_FIRST;
            rk_wr_data = k_first;
         end
         ST_KEY_S: rk_we = 1'b1;
         ST_KEY_LAST: begin
            rk_we      = 1'b1;
            rk_wr_addr = RK_LAST;
            rk_wr_data = k_last;
         end
         default: rk_we = 1'b0;
      endcase
   end

   // decryption walks the keys backward: 63 - n is the bitwise inverse
   assign rd_cnt     = (state_ff == ST_ROUND) ? cnt_ff + 1'b1 : '0;
   assign rk_rd_addr = mode_ff ? ~rd_cnt : rd_cnt;

   arxcbc_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (NROUNDS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_we),
      .wr_addr (rk_wr_addr),
      .wr_data (rk_wr_data),
      .rd_addr (rk_rd_addr),
      .rd_data (rk_rd_data)
   );

   quad_type round_in;

   arxcbc_round u_round (
      .state_in  (w_ff),
      .round_key (rk_rd_data),
      .inverse   (mode_ff),
      .state_out (round_in)
   );

   quad_type chain_eff;
   quad_type result;
   logic     out_free;

   assign chain_eff = restart_ff ? quad_type'({iv_hi_ff, iv_lo_ff}) : chain_ff;
   assign result    = mode_ff ? (w_ff ^ chain_ff) : w_ff;
   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         chain_ff      <= '0;
         keys_stale_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         restart_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_hit) begin
            keys_stale_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  blk_ff     <= {req_chan.block_hi, req_chan.block_lo};
                  restart_ff <= req_chan.chain_restart;
                  state_ff   <= keys_stale_ff ? ST_KEY_LOAD : ST_PREP;
               end
            end
            ST_KEY_LOAD: begin
               for (int k = 0; k < 4; k++) begin
                  s_ff[k] <= k_first[k] + MIX_CONST[k];
               end
               t_ff     <= k_last;
               cnt_ff   <= RK_FIRST + 1'b1;
               state_ff <= ST_KEY_S;
            end
            ST_KEY_S: begin
               s_ff     <= s_mix_in;
               state_ff <= ST_KEY_T;
            end
            ST_KEY_T: begin
               t_ff   <= t_mix_in;
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == RK_MIX_LAST) ? ST_KEY_LAST : ST_KEY_S;
            end
            ST_KEY_LAST: begin
               keys_stale_ff <= 1'b0;
               state_ff      <= ST_PREP;
            end
            ST_PREP: begin
               chain_ff <= chain_eff;
               w_ff     <= mode_ff ? blk_ff : (blk_ff ^ chain_eff);
               cnt_ff   <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               w_ff     <= round_in;
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == RK_LAST) ? ST_DONE : ST_ROUND;
            end
            ST_DONE: begin
               // hold until the output register is free
               if (out_free) begin
                  out_ff       <= result;
                  rsp_valid_ff <= 1'b1;
                  chain_ff     <= mode_ff ? blk_ff : w_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.out_hi = out_ff[BLOCK_W-1:HALF_W];
   assign rsp_chan.out_lo = out_ff[HALF_W-1:0];

endmodule

FILE: rtl/arxcbc_checker.sv
// ----------------------------------------------------------------------------
// arxcbc_checker: port-level checks of the ARX CBC block cipher
// Watches the request and response beats and the block's busy window.
// ----------------------------------------------------------------------------
module arxcbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [arxcbc_pkg::HALF_W-1:0] rsp_out_hi,
   input logic [arxcbc_pkg::HALF_W-1:0] rsp_out_lo
);
   import arxcbc_pkg::*;

   logic pend_ff;
   logic rv_q_ff;
   logic taken_q_ff;
   logic new_rsp;

   // a result beat appears that was not there or was just taken
   assign new_rsp = rsp_valid & (~rv_q_ff | taken_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         rv_q_ff    <= 1'b0;
         taken_q_ff <= 1'b0;
      end else begin
         rv_q_ff    <= rsp_valid;
         taken_q_ff <= rsp_valid & rsp_ready;
         if (req_valid && req_ready) begin
            pend_ff <= 1'b1;
         end else if (new_rsp) begin
            pend_ff <= 1'b0;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_hi) && $stable(rsp_out_lo))
      else $error("stalled result beat changed");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      new_rsp |-> pend_ff)
      else $error("result beat without an accepted input");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !new_rsp |-> !req_ready)
      else $error("input taken while a block is in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind arx_block_cipher_cbc_unit arxcbc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_out_hi (rsp_chan.out_hi),
   .rsp_out_lo (rsp_chan.out_lo)
);
